>>> design/assr_pkg.sv
// Shared types and constants for the averaged step speed regulator.
// Holds field widths, configuration register indexes, controller states and the
// command/status structs between the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package assr_pkg;

  // Field widths and number formats
  localparam int FREQ_FRAC_BITS = 8;
  localparam int SUM_WIDTH      = 40;
  localparam int FREQ_W         = 24;
  localparam int TARGET_W       = 15;
  localparam int DAC_W          = 16;
  localparam int STEP_W         = 15;
  localparam int N_W            = 16;
  localparam int TOL_W          = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;
  localparam int S_TDATA_W      = 64;
  localparam int M_TDATA_W      = 40;
  localparam int DIV_CNT_W      = $clog2(SUM_WIDTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_MAX   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [N_W-1:0]          RST_SAMPLES  = 16'd16;
  localparam logic [TOL_W-1:0]        RST_TOL      = 24'd26;
  localparam logic [STEP_W-1:0]       RST_STEP     = 15'd1;
  localparam logic signed [DAC_W-1:0] RST_DAC_MIN  = -16'sd2048;
  localparam logic signed [DAC_W-1:0] RST_DAC_MAX  = 16'sd2047;

  // Item kinds carried in the input tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIVIDE,
    ST_COMPARE,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit_simple;
    logic div_start;
    logic compare;
    logic commit_decide;
  } dp_cmd_t;

  typedef struct packed {
    logic simple_item;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/assr_div.sv
// Restoring divider for the window average: SUM_WIDTH-bit dividend by N_W-bit divisor.
// One quotient bit per cycle. Depends on assr_pkg.
`timescale 1ns / 1ps

module assr_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [assr_pkg::SUM_WIDTH-1:0] dividend,
  input  logic [assr_pkg::N_W-1:0]       divisor,
  output logic [assr_pkg::SUM_WIDTH-1:0] quotient,
  output logic                           done
);
  import assr_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_WIDTH-1:0] quo;
  logic [N_W-1:0]       rem;
  logic [N_W-1:0]       dvs;
  logic [N_W:0]         shifted;
  logic [N_W:0]         diff;
  logic                 fits;

  always_comb begin
    shifted = {rem, quo[SUM_WIDTH-1]};
    fits    = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SUM_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift register payload: no reset
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[SUM_WIDTH-2:0], fits};
      rem <= fits ? diff[N_W-1:0] : shifted[N_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

>>> design/assr_dp.sv
// Datapath of the speed regulator: configuration registers, captured item, regulator
// state, window accumulator, divider, comparisons and the output register.
// Depends on assr_pkg and assr_div.
`timescale 1ns / 1ps

module assr_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [assr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [assr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [assr_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [assr_pkg::M_TDATA_W-1:0]  m_tdata,
  input  assr_pkg::dp_cmd_t               cmd,
  output assr_pkg::dp_status_t            status
);
  import assr_pkg::*;

  // Configuration
  logic [N_W-1:0]          cfg_n;
  logic [TOL_W-1:0]        cfg_tol;
  logic [STEP_W-1:0]       cfg_step;
  logic signed [DAC_W-1:0] cfg_min;
  logic signed [DAC_W-1:0] cfg_max;

  // Captured item
  logic                    it_op;
  logic [FREQ_W-1:0]       it_freq;
  logic [TARGET_W-1:0]     it_target;
  logic signed [DAC_W-1:0] it_preset;
  logic                    it_preset_valid;
  logic                    it_paused;

  // Regulator state
  logic [TARGET_W-1:0]     target;
  logic signed [DAC_W-1:0] drive;
  logic                    adjust;
  logic [SUM_WIDTH-1:0]    sum;
  logic [N_W-1:0]          count;

  logic [TARGET_W-1:0]     target_next;
  logic signed [DAC_W-1:0] drive_next;
  logic                    adjust_next;
  logic [SUM_WIDTH-1:0]    sum_next;
  logic [N_W-1:0]          count_next;
  logic                    dac_wr_next;
  logic                    tab_wr_next;

  // Decision intermediates
  logic [SUM_WIDTH-1:0]    avg;
  logic                    div_done;
  logic [SUM_WIDTH-1:0]    tq;
  logic [SUM_WIDTH-1:0]    dev;
  logic                    avg_lt_tq;
  logic                    avg_lt_tol;
  logic                    dev_gt_tol;
  logic                    up_ok;
  logic                    dn_ok;
  logic signed [DAC_W:0]   drive_x;
  logic signed [DAC_W:0]   step_x;
  logic [N_W-1:0]          divisor;
  logic                    commit;

  // Output register
  logic                    out_valid;
  logic signed [DAC_W-1:0] out_dac;
  logic                    out_dac_wr;
  logic                    out_adjust;
  logic                    out_tab_wr;
  logic [TARGET_W-1:0]     out_tab_freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_n    <= RST_SAMPLES;
      cfg_tol  <= RST_TOL;
      cfg_step <= RST_STEP;
      cfg_min  <= RST_DAC_MIN;
      cfg_max  <= RST_DAC_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLES:   cfg_n    <= cfg_data[N_W-1:0];
        CFG_TOLERANCE: cfg_tol  <= cfg_data[TOL_W-1:0];
        CFG_DAC_STEP:  cfg_step <= cfg_data[STEP_W-1:0];
        CFG_DAC_MIN:   cfg_min  <= cfg_data[DAC_W-1:0];
        CFG_DAC_MAX:   cfg_max  <= cfg_data[DAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_op           <= s_tuser;
      it_freq         <= s_tdata[23:0];
      it_target       <= s_tdata[38:24];
      it_preset       <= s_tdata[54:39];
      it_preset_valid <= s_tdata[55];
      it_paused       <= s_tdata[56];
    end
  end

  // A zero window length decides on every sample with divisor one
  assign divisor = (cfg_n == '0) ? N_W'(1) : cfg_n;

  assr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (divisor),
    .quotient (avg),
    .done     (div_done)
  );

  assign tq = SUM_WIDTH'({target, {FREQ_FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      avg_lt_tq  <= avg < tq;
      avg_lt_tol <= avg < SUM_WIDTH'(cfg_tol);
      dev        <= (tq > avg) ? tq - avg : avg - tq;
    end
  end

  always_comb begin
    drive_x    = {drive[DAC_W-1], drive};
    step_x     = {2'b00, cfg_step};
    dev_gt_tol = dev > SUM_WIDTH'(cfg_tol);
    up_ok      = (drive_x < ($signed({cfg_max[DAC_W-1], cfg_max}) - step_x)) && !it_paused;
    dn_ok      = (drive_x > ($signed({cfg_min[DAC_W-1], cfg_min}) + step_x)) && !it_paused;

    target_next = target;
    drive_next  = drive;
    adjust_next = adjust;
    sum_next    = sum;
    count_next  = count;
    dac_wr_next = 1'b0;
    tab_wr_next = 1'b0;

    if (cmd.commit_simple) begin
      if (it_op == OP_TARGET) begin
        target_next = it_target;
        adjust_next = 1'b1;
        dac_wr_next = 1'b1;
        if (it_target == '0) begin
          drive_next = cfg_min;
        end else if (it_preset_valid) begin
          drive_next = it_preset;
        end
      end else begin
        sum_next   = sum + SUM_WIDTH'(it_freq);
        count_next = count + 1'b1;
      end
    end else begin
      // Decision on the sample after a full window
      if (dev_gt_tol && target != '0) begin
        adjust_next = 1'b1;
        if (avg_lt_tq) begin
          if (up_ok) begin
            drive_next  = drive + DAC_W'(cfg_step);
            dac_wr_next = 1'b1;
          end
        end else if (dn_ok) begin
          drive_next  = drive - DAC_W'(cfg_step);
          dac_wr_next = 1'b1;
        end
      end else if (adjust) begin
        if (target != '0) begin
          tab_wr_next = 1'b1;
          adjust_next = 1'b0;
        end else if (avg_lt_tol) begin
          adjust_next = 1'b0;
        end
      end
      sum_next   = SUM_WIDTH'(it_freq);
      count_next = N_W'(1);
    end
  end

  assign commit = cmd.commit_simple || cmd.commit_decide;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      drive  <= '0;
      adjust <= 1'b0;
      sum    <= '0;
      count  <= '0;
    end else if (commit) begin
      target <= target_next;
      drive  <= drive_next;
      adjust <= adjust_next;
      sum    <= sum_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_dac      <= drive_next;
      out_dac_wr   <= dac_wr_next;
      out_adjust   <= adjust_next;
      out_tab_wr   <= tab_wr_next;
      out_tab_freq <= tab_wr_next ? target_next : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_tab_freq, out_tab_wr, out_adjust, out_dac_wr, out_dac};

  assign status.simple_item = (it_op == OP_TARGET) || (count < cfg_n);
  assign status.div_done    = div_done;
  assign status.out_free    = !out_valid || m_tready;

endmodule

>>> design/assr_ctrl.sv
// Controller state machine of the speed regulator: sequences capture, divide,
// compare and commit of one item at a time. Depends on assr_pkg.
`timescale 1ns / 1ps

module assr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  assr_pkg::dp_status_t status,
  output assr_pkg::dp_cmd_t    cmd
);
  import assr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!status.simple_item) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end else if (status.out_free) begin
          cmd.commit_simple = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.out_free) begin
          cmd.commit_decide = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/averaged_step_speed_regulator_top.sv
// Top level of the averaged step speed regulator.
// Joins the controller (assr_ctrl) and the datapath (assr_dp). Depends on assr_pkg.
`timescale 1ns / 1ps

// Bang-bang speed regulator with a deadband. Each transfer on the slave side is either
// a measured frequency sample or a new target; each produces exactly one result transfer
// on the master side carrying the DAC drive value and the write/adjust/table flags.
// Samples are summed over a window of samples_per_decision samples; the sample after a
// full window starts a decision: the sum is floor-divided by the window length, compared
// against target << 8 with the tolerance band, and the DAC value steps by dac_step when
// allowed. That sample then opens the next window. A target transfer or a sample that
// only accumulates is captured on acceptance and reaches the result register from the
// dispatch state. A deciding sample passes from dispatch to the restoring divider, which
// retires one quotient bit per cycle over the 40-bit window sum, then to a step that sees
// the divider finish, a step to compare and a step to commit. One item is processed at
// a time; the next item is accepted while the previous result still waits in the output
// register, and processing holds at its commit step while that register is occupied.
// Configuration writes are taken on any cycle with cfg_we high; indexes 5 to 7 are
// ignored. Write configuration only while no item is in flight.

module averaged_step_speed_regulator_top (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [assr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [assr_pkg::CFG_DATA_W-1:0] cfg_data,
  // Slave stream: measured samples and target updates
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata from bit 0: frequency_sample[23:0], target_freq[38:24],
  // preset_dac[54:39], preset_valid[55], paused[56], zero pad[63:57]
  input  logic [assr_pkg::S_TDATA_W-1:0]  s_tdata,
  // s_tuser: opcode (0 sample, 1 new target)
  input  logic                            s_tuser,
  // Master stream: regulator results
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata from bit 0: dac_value[15:0], dac_write[16], adjusting[17],
  // table_write[18], table_freq[33:19], zero pad[39:34]
  output logic [assr_pkg::M_TDATA_W-1:0]  m_tdata
);
  import assr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence one item at a time
  assr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold configuration, regulator state, divider and result register
  assr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
